/* sv/fswc_pkg.sv */
// Shared types and constants of the flash sector write cache policy unit.
// Holds request codes, action codes, the request flag bundle and the status bundle.
// No dependencies.
package fswc_pkg;

    // Fixed field widths
    localparam int KIND_W   = 2;
    localparam int BLOCK_W  = 16;
    localparam int ACTION_W = 4;
    localparam int ADDR_W   = 24;
    localparam int SLOT_W   = 3;
    localparam int SECTOR_W = 12;
    localparam int PBLK_W   = 15;
    localparam int FS_W     = 13;
    localparam int MASK_W   = 8;

    // Sector count limits and reset value
    localparam logic [FS_W-1:0] FS_MAX   = 13'd4096;
    localparam logic [FS_W-1:0] FS_MIN   = 13'd1;
    localparam logic [FS_W-1:0] FS_RESET = 13'd512;
    localparam logic [SECTOR_W-1:0] SECTOR_LAST = 12'd4095;

    // Configuration register indexes
    localparam int CFG_ADDR_W = 1;
    localparam logic [CFG_ADDR_W-1:0] REG_FLASH_SECTORS = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_BUFFER_IN_RAM = 1'd1;

    typedef enum logic [KIND_W-1:0] {
        KIND_READ  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_SYNC  = 2'd2
    } kind_t;

    typedef enum logic [ACTION_W-1:0] {
        ACT_NONE        = 4'd0,
        ACT_BAD         = 4'd1,
        ACT_STORE       = 4'd2,
        ACT_OPEN_STORE  = 4'd3,
        ACT_FLUSH_STORE = 4'd4,
        ACT_PART        = 4'd5,
        ACT_READ_CACHE  = 4'd6,
        ACT_READ_FLASH  = 4'd7,
        ACT_FLUSH       = 4'd8
    } action_t;

    // Request flags carried from the decode stage to the policy stage
    typedef struct packed {
        kind_t kind;
        logic  is_zero;
        logic  in_range;
    } fswc_req_t;

    // Cache state seen by the top level
    typedef struct packed {
        logic              sector_open;
        logic [MASK_W-1:0] dirty_blocks;
    } fswc_status_t;

endpackage

/* sv/fswc_decode.sv */
// Decode stage: range check and reciprocal products for sector and slot.
// Takes the registered request and registers products for the policy stage.
// Depends on fswc_pkg.
module fswc_decode #(
    parameter int BLOCK_BYTES  = 512,
    parameter int SECTOR_BYTES = 4096,
    localparam int BPS_RAW  = SECTOR_BYTES / BLOCK_BYTES,
    localparam int BPS      = (BPS_RAW > 0) ? BPS_RAW : 1,
    localparam int SPAN_RAW = 12 + $clog2(BPS + 1),
    localparam int SPAN_W   = (SPAN_RAW > 16) ? SPAN_RAW : 16,
    localparam int FA_W     = fswc_pkg::BLOCK_W + $clog2(BLOCK_BYTES),
    localparam int Q_RAW    = FA_W - $clog2(SECTOR_BYTES) + 1,
    localparam int Q_W      = (Q_RAW > 12) ? Q_RAW : 12
) (
    input  logic                                   clk,
    input  logic                                   en,
    input  fswc_pkg::kind_t                        kind,
    input  logic [fswc_pkg::BLOCK_W-1:0]           block,
    input  logic [SPAN_W-1:0]                      span,
    output fswc_pkg::fswc_req_t                    req,
    output logic [fswc_pkg::BLOCK_W-1:0]           x,
    output logic [FA_W-1:0]                        faddr,
    output logic [Q_W-1:0]                         q_est,
    output logic [fswc_pkg::BLOCK_W-1:0]           qs_est
);

    localparam int SHQ     = fswc_pkg::BLOCK_W + $clog2(SECTOR_BYTES);
    localparam int PQ_W    = SHQ + Q_W;
    localparam logic [63:0] MQ = ((64'd1 << SHQ) * BLOCK_BYTES) / SECTOR_BYTES;
    localparam int SHS     = fswc_pkg::BLOCK_W + $clog2(BPS);
    localparam int PS_W    = SHS + fswc_pkg::BLOCK_W;
    localparam logic [63:0] MS = (64'd1 << SHS) / BPS;

    logic [fswc_pkg::BLOCK_W-1:0] x_c;
    logic [PQ_W-1:0]              prod_q;
    logic [PS_W-1:0]              prod_s;
    fswc_pkg::fswc_req_t          req_c;

    fswc_pkg::fswc_req_t          req_reg;
    logic [fswc_pkg::BLOCK_W-1:0] x_reg;
    logic [FA_W-1:0]              faddr_reg;
    logic [Q_W-1:0]               q_reg;
    logic [fswc_pkg::BLOCK_W-1:0] qs_reg;

    // Offset from the first data block, and range check against the span
    assign x_c            = block - fswc_pkg::BLOCK_W'(1);
    assign req_c.kind     = kind;
    assign req_c.is_zero  = (block == '0);
    assign req_c.in_range = (SPAN_W'(x_c) < span);

    // Reciprocal products, corrected in the policy stage
    assign prod_q = PQ_W'(x_c) * MQ[PQ_W-1:0];
    assign prod_s = PS_W'(x_c) * MS[PS_W-1:0];

    // Hold the decode results while the next stage stalls
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            req_reg   <= req_c;
            x_reg     <= x_c;
            faddr_reg <= FA_W'(x_c) * FA_W'(BLOCK_BYTES);
            q_reg     <= prod_q[SHQ +: Q_W];
            qs_reg    <= prod_s[SHS +: fswc_pkg::BLOCK_W];
        end
    end

    assign req    = req_reg;
    assign x      = x_reg;
    assign faddr  = faddr_reg;
    assign q_est  = q_reg;
    assign qs_est = qs_reg;

endmodule

/* sv/fswc_policy.sv */
// Policy stage: quotient correction, cache state and the result register.
// Decides one action per request from the open sector and dirty mask.
// Depends on fswc_pkg.
module fswc_policy #(
    parameter int BLOCK_BYTES  = 512,
    parameter int SECTOR_BYTES = 4096,
    localparam int BPS_RAW  = SECTOR_BYTES / BLOCK_BYTES,
    localparam int BPS      = (BPS_RAW > 0) ? BPS_RAW : 1,
    localparam int SPAN_RAW = 12 + $clog2(BPS + 1),
    localparam int SPAN_W   = (SPAN_RAW > 16) ? SPAN_RAW : 16,
    localparam int FA_W     = fswc_pkg::BLOCK_W + $clog2(BLOCK_BYTES),
    localparam int Q_RAW    = FA_W - $clog2(SECTOR_BYTES) + 1,
    localparam int Q_W      = (Q_RAW > 12) ? Q_RAW : 12
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  en,
    input  logic                                  take,
    input  fswc_pkg::fswc_req_t                   req,
    input  logic [fswc_pkg::BLOCK_W-1:0]          x,
    input  logic [FA_W-1:0]                       faddr,
    input  logic [Q_W-1:0]                        q_est,
    input  logic [fswc_pkg::BLOCK_W-1:0]          qs_est,
    input  logic [SPAN_W-1:0]                     span,
    input  logic [fswc_pkg::ADDR_W-1:0]           scratch_base,
    input  logic                                  buffer_in_ram,
    output fswc_pkg::action_t                     action,
    output logic [fswc_pkg::ADDR_W-1:0]           flash_address,
    output logic [fswc_pkg::SLOT_W-1:0]           cache_slot,
    output logic [fswc_pkg::SECTOR_W-1:0]         writeback_sector,
    output logic [fswc_pkg::PBLK_W-1:0]           partition_blocks,
    output fswc_pkg::fswc_status_t                status
);

    logic [FA_W-1:0]                  rem_q;
    logic [Q_W-1:0]                   q_fix;
    logic [fswc_pkg::SECTOR_W-1:0]    sector;
    logic [fswc_pkg::BLOCK_W-1:0]     rem_s;
    logic [fswc_pkg::BLOCK_W-1:0]     rem_s_fix;
    logic [fswc_pkg::SLOT_W-1:0]      slot;
    logic [fswc_pkg::MASK_W-1:0]      slot_bit;
    logic [fswc_pkg::ADDR_W-1:0]      cache_addr;
    logic                             same;
    logic                             hit;

    logic                             open_reg;
    logic                             open_next;
    logic [fswc_pkg::SECTOR_W-1:0]    sector_reg;
    logic [fswc_pkg::SECTOR_W-1:0]    sector_next;
    logic [fswc_pkg::MASK_W-1:0]      dirty_reg;
    logic [fswc_pkg::MASK_W-1:0]      dirty_next;

    fswc_pkg::action_t                action_next;
    logic [fswc_pkg::ADDR_W-1:0]      addr_next;
    logic [fswc_pkg::SLOT_W-1:0]      slot_next;
    logic [fswc_pkg::SECTOR_W-1:0]    wb_next;
    logic [fswc_pkg::PBLK_W-1:0]      pblk_next;

    fswc_pkg::action_t                action_reg;
    logic [fswc_pkg::ADDR_W-1:0]      addr_reg;
    logic [fswc_pkg::SLOT_W-1:0]      slot_reg;
    logic [fswc_pkg::SECTOR_W-1:0]    wb_reg;
    logic [fswc_pkg::PBLK_W-1:0]      pblk_reg;

    // Fix up the sector quotient, which may come in one short
    assign rem_q  = faddr - FA_W'(q_est) * FA_W'(SECTOR_BYTES);
    assign q_fix  = (rem_q >= FA_W'(SECTOR_BYTES)) ? q_est + Q_W'(1) : q_est;
    assign sector = q_fix[fswc_pkg::SECTOR_W-1:0];

    // Fix up the slot remainder the same way
    assign rem_s     = x - qs_est * fswc_pkg::BLOCK_W'(BPS);
    assign rem_s_fix = (rem_s >= fswc_pkg::BLOCK_W'(BPS)) ?
                       rem_s - fswc_pkg::BLOCK_W'(BPS) : rem_s;
    assign slot      = rem_s_fix[fswc_pkg::SLOT_W-1:0];
    assign slot_bit  = fswc_pkg::MASK_W'(1) << slot;

    // Cache copy lives in RAM (address zero) or in the scratch sector
    assign cache_addr = buffer_in_ram ? '0 :
        scratch_base + fswc_pkg::ADDR_W'(slot) * fswc_pkg::ADDR_W'(BLOCK_BYTES);

    assign same = open_reg && (sector_reg == sector);
    assign hit  = (dirty_reg & slot_bit) != '0;

    // Decide the action and the next cache state
    always_comb
    begin
        open_next   = open_reg;
        sector_next = sector_reg;
        dirty_next  = dirty_reg;
        action_next = fswc_pkg::ACT_NONE;
        addr_next   = '0;
        slot_next   = '0;
        wb_next     = '0;
        pblk_next   = '0;
        case (req.kind)
            fswc_pkg::KIND_SYNC:
            begin
                if (open_reg)
                begin
                    action_next = fswc_pkg::ACT_FLUSH;
                    wb_next     = sector_reg;
                    open_next   = 1'b0;
                    dirty_next  = '0;
                end
            end
            fswc_pkg::KIND_READ, fswc_pkg::KIND_WRITE:
            begin
                if (req.is_zero)
                begin
                    if (req.kind == fswc_pkg::KIND_READ)
                    begin
                        action_next = fswc_pkg::ACT_PART;
                        pblk_next   = span[fswc_pkg::PBLK_W-1:0];
                    end
                end
                else if (!req.in_range)
                begin
                    action_next = fswc_pkg::ACT_BAD;
                end
                else
                begin
                    slot_next = slot;
                    if (req.kind == fswc_pkg::KIND_READ)
                    begin
                        if (same && hit)
                        begin
                            action_next = fswc_pkg::ACT_READ_CACHE;
                            addr_next   = cache_addr;
                        end
                        else
                        begin
                            action_next = fswc_pkg::ACT_READ_FLASH;
                            addr_next   = faddr[fswc_pkg::ADDR_W-1:0];
                        end
                    end
                    else
                    begin
                        addr_next = cache_addr;
                        if (!same || hit)
                        begin
                            if (open_reg)
                            begin
                                action_next = fswc_pkg::ACT_FLUSH_STORE;
                                wb_next     = sector_reg;
                            end
                            else
                            begin
                                action_next = fswc_pkg::ACT_OPEN_STORE;
                            end
                            open_next   = 1'b1;
                            sector_next = sector;
                            dirty_next  = slot_bit;
                        end
                        else
                        begin
                            action_next = fswc_pkg::ACT_STORE;
                            dirty_next  = dirty_reg | slot_bit;
                        end
                    end
                end
            end
            default:
            begin
                action_next = fswc_pkg::ACT_NONE;
            end
        endcase
    end

    // Advance the cache state once per request that moves into the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg   <= 1'b0;
            sector_reg <= '0;
            dirty_reg  <= '0;
        end
        else if (take)
        begin
            open_reg   <= open_next;
            sector_reg <= sector_next;
            dirty_reg  <= dirty_next;
        end
    end

    // Result register, held while the receiver stalls
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            action_reg <= action_next;
            addr_reg   <= addr_next;
            slot_reg   <= slot_next;
            wb_reg     <= wb_next;
            pblk_reg   <= pblk_next;
        end
    end

    assign action              = action_reg;
    assign flash_address       = addr_reg;
    assign cache_slot          = slot_reg;
    assign writeback_sector    = wb_reg;
    assign partition_blocks    = pblk_reg;
    assign status.sector_open  = open_reg;
    assign status.dirty_blocks = dirty_reg;

endmodule

/* sv/flash_sector_write_cache_policy_unit.sv */
// Top level of the flash sector write cache policy unit.
// Holds the configuration registers, the input register and the handshake.
// Depends on fswc_pkg, fswc_decode and fswc_policy.
//
// Usage:
//   Requests enter on the s_ stream: s_tuser carries the request kind
//   (read, write, sync) and s_tdata the logical block number. Each request
//   yields exactly one result on the m_ stream: m_tuser carries the action
//   code, m_tdata the byte address, cache slot, write-back sector and the
//   partition block count.
//   A request passes the input register, the decode register (reciprocal
//   products for sector and slot) and the result register, which drives
//   m_tvalid. One request is taken every cycle while m_tready is high;
//   the cache state (open sector, dirty mask) is updated with each result.
//   When the receiver holds m_tready low the result register holds, and the
//   earlier stages keep filling until all three are occupied; then s_tready
//   drops. Reset empties the pipeline, closes the cached sector, clears the
//   dirty mask and loads flash_sectors = 512 and buffer_in_ram = 1.
//   Configuration writes take effect at once; write them only while idle.
module flash_sector_write_cache_policy_unit #(
    parameter int BLOCK_BYTES  = 512,
    parameter int SECTOR_BYTES = 4096
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Configuration write port
    input  logic                                 cfg_we,
    input  logic [fswc_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [fswc_pkg::FS_W-1:0]            cfg_wdata,
    // Request stream
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [15:0]                          s_tdata,   // [15:0] block
    input  logic [1:0]                           s_tuser,   // [1:0] kind
    // Result stream
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [23:0] flash_address, [26:24] cache_slot, [38:27] writeback_sector,
    // [53:39] partition_blocks, [55:54] zero
    output logic [55:0]                          m_tdata,
    output logic [3:0]                           m_tuser    // [3:0] action
);

    localparam int BPS_RAW  = SECTOR_BYTES / BLOCK_BYTES;
    localparam int BPS      = (BPS_RAW > 0) ? BPS_RAW : 1;
    localparam int SPAN_RAW = 12 + $clog2(BPS + 1);
    localparam int SPAN_W   = (SPAN_RAW > 16) ? SPAN_RAW : 16;
    localparam int FA_W     = fswc_pkg::BLOCK_W + $clog2(BLOCK_BYTES);
    localparam int Q_RAW    = FA_W - $clog2(SECTOR_BYTES) + 1;
    localparam int Q_W      = (Q_RAW > 12) ? Q_RAW : 12;
    localparam int BASE_RAW = 12 + $clog2(SECTOR_BYTES + 1);
    localparam int BASE_W   = (BASE_RAW > 24) ? BASE_RAW : 24;

    logic [fswc_pkg::FS_W-1:0]        fs_reg;
    logic                             ram_reg;
    logic [fswc_pkg::FS_W-1:0]        fs_m1;
    logic [fswc_pkg::SECTOR_W-1:0]    eff_m1;
    logic [SPAN_W-1:0]                span;
    logic [BASE_W-1:0]                base_full;

    logic                             v0_reg;
    logic                             v1_reg;
    logic                             v2_reg;
    logic                             en0;
    logic                             en1;
    logic                             en2;
    fswc_pkg::kind_t                  kind_reg;
    logic [fswc_pkg::BLOCK_W-1:0]     block_reg;

    fswc_pkg::fswc_req_t              req;
    logic [fswc_pkg::BLOCK_W-1:0]     x;
    logic [FA_W-1:0]                  faddr;
    logic [Q_W-1:0]                   q_est;
    logic [fswc_pkg::BLOCK_W-1:0]     qs_est;

    fswc_pkg::action_t                action;
    logic [fswc_pkg::ADDR_W-1:0]      flash_address;
    logic [fswc_pkg::SLOT_W-1:0]      cache_slot;
    logic [fswc_pkg::SECTOR_W-1:0]    writeback_sector;
    logic [fswc_pkg::PBLK_W-1:0]      partition_blocks;
    fswc_pkg::fswc_status_t           status;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fs_reg  <= fswc_pkg::FS_RESET;
            ram_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                fswc_pkg::REG_FLASH_SECTORS: fs_reg  <= cfg_wdata;
                fswc_pkg::REG_BUFFER_IN_RAM: ram_reg <= cfg_wdata[0];
                default:                     fs_reg  <= fs_reg;
            endcase
        end
    end

    // Clamp the sector count; derive data span and scratch sector base
    assign fs_m1 = fs_reg - fswc_pkg::FS_MIN;
    always_comb
    begin
        if (fs_reg <= fswc_pkg::FS_MIN)
        begin
            eff_m1 = '0;
        end
        else if (fs_reg > fswc_pkg::FS_MAX)
        begin
            eff_m1 = fswc_pkg::SECTOR_LAST;
        end
        else
        begin
            eff_m1 = fs_m1[fswc_pkg::SECTOR_W-1:0];
        end
    end
    assign span      = SPAN_W'(eff_m1) * SPAN_W'(BPS);
    assign base_full = BASE_W'(eff_m1) * BASE_W'(SECTOR_BYTES);

    // Stage enables: a stage loads when it is empty or its successor loads
    assign en2      = !v2_reg || m_tready;
    assign en1      = !v1_reg || en2;
    assign en0      = !v0_reg || en1;
    assign s_tready = en0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (en0)
            begin
                v0_reg <= s_tvalid;
            end
            if (en1)
            begin
                v1_reg <= v0_reg;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
        end
    end

    // Input register
    always_ff @(posedge clk)
    begin
        if (en0)
        begin
            kind_reg  <= fswc_pkg::kind_t'(s_tuser);
            block_reg <= s_tdata;
        end
    end

    fswc_decode #(
        .BLOCK_BYTES  (BLOCK_BYTES),
        .SECTOR_BYTES (SECTOR_BYTES)
    ) u_decode (
        .clk    (clk),
        .en     (en1),
        .kind   (kind_reg),
        .block  (block_reg),
        .span   (span),
        .req    (req),
        .x      (x),
        .faddr  (faddr),
        .q_est  (q_est),
        .qs_est (qs_est)
    );

    fswc_policy #(
        .BLOCK_BYTES  (BLOCK_BYTES),
        .SECTOR_BYTES (SECTOR_BYTES)
    ) u_policy (
        .clk              (clk),
        .rst_n            (rst_n),
        .en               (en2),
        .take             (en2 && v1_reg),
        .req              (req),
        .x                (x),
        .faddr            (faddr),
        .q_est            (q_est),
        .qs_est           (qs_est),
        .span             (span),
        .scratch_base     (base_full[fswc_pkg::ADDR_W-1:0]),
        .buffer_in_ram    (ram_reg),
        .action           (action),
        .flash_address    (flash_address),
        .cache_slot       (cache_slot),
        .writeback_sector (writeback_sector),
        .partition_blocks (partition_blocks),
        .status           (status)
    );

    // Pack the result transfer
    assign m_tvalid = v2_reg;
    assign m_tuser  = action;
    assign m_tdata  = {2'b00, partition_blocks, writeback_sector, cache_slot, flash_address};

    // A full stall means every stage holds an item
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (v0_reg && v1_reg && v2_reg))
        else $error("input stalled with an empty stage");

    // The dirty mask is clear whenever no sector is cached
    a_clean_when_closed: assert property (@(posedge clk) disable iff (!rst_n)
        !status.sector_open |-> (status.dirty_blocks == '0))
        else $error("dirty blocks with no open sector");

    // An open sector always holds at least one dirty block
    a_open_is_dirty: assert property (@(posedge clk) disable iff (!rst_n)
        status.sector_open |-> (status.dirty_blocks != '0))
        else $error("open sector with a clean mask");

    // Cache accesses in RAM carry address zero
    a_ram_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && ram_reg && (m_tuser == fswc_pkg::ACT_READ_CACHE))
        |-> (flash_address == '0))
        else $error("RAM cache read with a flash address");

endmodule
